// ===== rtl/core/cbc_pkg.sv =====
// Shared types, widths, register codes and tables of the ohmmeter color band coder.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package cbc_pkg;

    // Field and register widths
    localparam int SAMPLE_W     = 12;
    localparam int KNOWN_W      = 20;
    localparam int SPR_W        = 10;
    localparam int FSC_W        = 12;
    localparam int N_W          = SPR_W + 1;        // count of samples, 1..1024
    localparam int DEN_W        = FSC_W + N_W;      // full_scale * count
    localparam int MEAN_W       = 12;
    localparam int RES_W        = 32;
    localparam int DIGIT_W      = 4;
    localparam int MULT_W       = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 20;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int QUEUE_DEPTH     = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KNOWN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FSC   = 2'd2;

    // Register reset values
    localparam logic [KNOWN_W-1:0] KNOWN_RST = 20'd10000;
    localparam logic [SPR_W-1:0]   SPR_RST   = 10'd500;
    localparam logic [FSC_W-1:0]   FSC_RST   = 12'd4095;

    localparam logic [MEAN_W-1:0] MEAN_MAX = 12'd4095;

    // Band selection: decade thresholds, scale per decade, clamp of the scaled input
    localparam int SNUM_W    = 20;
    localparam int SCALE_W   = 14;
    localparam int E_CLAMP   = 919999;      // anything above scales to >= 92, snaps to 91
    localparam int DEC_TH_4  = 100000;
    localparam int DEC_TH_3  = 10000;
    localparam int DEC_TH_2  = 1000;
    localparam int DEC_TH_1  = 100;

    localparam logic [MULT_W-1:0] MULT_0 = 3'd0;
    localparam logic [MULT_W-1:0] MULT_1 = 3'd1;
    localparam logic [MULT_W-1:0] MULT_2 = 3'd2;
    localparam logic [MULT_W-1:0] MULT_3 = 3'd3;
    localparam logic [MULT_W-1:0] MULT_4 = 3'd4;

    localparam int E24_N = 24;
    localparam int E24_IDX_W = 5;

    localparam logic [6:0] E24_VAL [E24_N] = '{
        7'd10, 7'd11, 7'd12, 7'd13, 7'd15, 7'd16, 7'd18, 7'd20, 7'd22, 7'd24, 7'd27, 7'd30,
        7'd33, 7'd36, 7'd39, 7'd43, 7'd47, 7'd51, 7'd56, 7'd62, 7'd68, 7'd75, 7'd82, 7'd91
    };
    localparam logic [DIGIT_W-1:0] E24_TENS [E24_N] = '{
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2, 4'd2, 4'd3,
        4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd8, 4'd9
    };
    localparam logic [DIGIT_W-1:0] E24_UNITS [E24_N] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd8, 4'd0, 4'd2, 4'd4, 4'd7, 4'd0,
        4'd3, 4'd6, 4'd9, 4'd3, 4'd7, 4'd1, 4'd6, 4'd2, 4'd8, 4'd5, 4'd2, 4'd1
    };

    typedef struct packed {
        logic [MEAN_W-1:0]  mean_code;
        logic [RES_W-1:0]   resistance_ohms;
        logic               open_circuit;
        logic [DIGIT_W-1:0] first_digit;
        logic [DIGIT_W-1:0] second_digit;
        logic [MULT_W-1:0]  multiplier;
    } t_result;

    // Nearest E24 entry, ties to the lower one: step past entry j when 2s exceeds
    // the sum of entry j and j+1. The table is sorted, so the count is the index.
    function automatic logic [E24_IDX_W-1:0] snap_index(input logic [6:0] s);
        logic [E24_IDX_W-1:0] idx;
        logic [7:0]           mid;
        idx = '0;
        for (int j = 0; j < E24_N - 1; j++) begin
            mid = {1'b0, E24_VAL[j]} + {1'b0, E24_VAL[j+1]};
            if ({s, 1'b0} > mid) begin
                idx = idx + 1'b1;
            end
        end
        return idx;
    endfunction

    function automatic logic [SCALE_W-1:0] decade_scale(input logic [MULT_W-1:0] mult);
        logic [SCALE_W-1:0] sc;
        case (mult)
            MULT_4:  sc = 14'd10000;
            MULT_3:  sc = 14'd1000;
            MULT_2:  sc = 14'd100;
            MULT_1:  sc = 14'd10;
            default: sc = 14'd1;
        endcase
        return sc;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cbc_if.sv =====
// Handshake channels of the color band coder: sample in, reading out, register writes.
// Depends on cbc_pkg for widths and the reading struct.
`default_nettype none

interface cbc_sample_if;
    logic                          valid;
    logic                          ready;
    logic [cbc_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface cbc_result_if;
    logic             valid;
    logic             ready;
    cbc_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cbc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cbc_pkg::CFG_IDX_W-1:0]  index;
    logic [cbc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ohmmeter_color_band_coder.sv =====
// Top level of the ohmmeter color band coder: register file, accumulator, queue, back end.
// Depends on cbc_pkg, cbc_if, cbc_front, cbc_queue and cbc_back.
//
// Each accepted converter sample is added to a running sum; after samples_per_reading
// samples the (sum, count) word goes into a two-entry queue and the sum restarts. The
// back end turns each word into one reading: rounded mean code, divider resistance
// rounded and saturated at 2^32-1, and three color bands (two E24 digits and a decade
// multiplier 0..4); a zero or negative denominator flags open circuit. All divisions
// share one restoring divider that yields one quotient bit per cycle; an open-circuit
// reading skips the resistance and band divisions. Samples keep being accepted while a
// reading is worked on, until the queue holds two unfinished readings. The user must
// write registers only while the block is idle; the block itself does not enforce it.
// The configuration channel is always ready.
`default_nettype none

module ohmmeter_color_band_coder #(
    parameter int SAMPLE_BITS = cbc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    cbc_sample_if.sink   i_smp,
    cbc_cfg_if.sink      i_cfg,
    cbc_result_if.source o_res
);
    import cbc_pkg::*;

    localparam int SW  = SAMPLE_BITS + 10;
    localparam int QDW = SW + N_W;

    logic [KNOWN_W-1:0] r_known;
    logic [SPR_W-1:0]   r_spr;
    logic [FSC_W-1:0]   r_fsc;

    logic               push, push_ready;
    logic [QDW-1:0]     push_data;
    logic               q_valid, q_pop;
    logic [QDW-1:0]     q_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known <= KNOWN_RST;
            r_spr   <= SPR_RST;
            r_fsc   <= FSC_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_KNOWN: r_known <= i_cfg.data[KNOWN_W-1:0];
                REG_SPR:   r_spr   <= i_cfg.data[SPR_W-1:0];
                REG_FSC:   r_fsc   <= i_cfg.data[FSC_W-1:0];
                default:   ;
            endcase
        end
    end

    cbc_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_smp        (i_smp),
        .i_spr        (r_spr),
        .o_push       (push),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    cbc_queue #(
        .WIDTH (QDW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_ready (push_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    cbc_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .i_known   (r_known),
        .i_fsc     (r_fsc),
        .o_res     (o_res)
    );

    // open circuit: saturated resistance, bands cleared
    a_open_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.open_circuit) |->
            (o_res.data.resistance_ohms == '1 && o_res.data.first_digit == '0 &&
             o_res.data.second_digit == '0 && o_res.data.multiplier == '0))
        else $error("open reading with bands or finite resistance");

    // a closed-circuit reading always carries band digits and a multiplier in range
    a_band_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.data.open_circuit) |->
            (o_res.data.first_digit != '0 && o_res.data.first_digit <= 4'd9 &&
             o_res.data.second_digit <= 4'd9 && o_res.data.multiplier <= MULT_4))
        else $error("band digits or multiplier out of range");

    // samples are refused only while the queue holds two pending readings
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_smp.ready |-> q_valid)
        else $error("sample input stalled with an empty queue");

endmodule

`default_nettype wire

// ===== rtl/core/cbc_front.sv =====
// Sample accumulator: sums samples and hands a finished (sum, count) word to the queue.
// Depends on cbc_pkg and cbc_sample_if.
`default_nettype none

module cbc_front #(
    parameter int SAMPLE_BITS = cbc_pkg::SAMPLE_BITS_DEF,
    localparam int SW = SAMPLE_BITS + 10
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    cbc_sample_if.sink                       i_smp,
    input  wire logic [cbc_pkg::SPR_W-1:0]   i_spr,
    output logic                             o_push,
    output logic [SW+cbc_pkg::N_W-1:0]       o_push_data,
    input  wire logic                        i_push_ready
);
    import cbc_pkg::*;

    logic [SW-1:0]    r_sum, n_sum;
    logic [SPR_W-1:0] r_count, n_count;
    logic [SPR_W-1:0] target;
    logic [N_W-1:0]   n_total;
    logic             take;
    logic             fire;

    assign i_smp.ready = i_push_ready;
    assign take        = i_smp.valid && i_push_ready;

    always_comb begin
        target  = (i_spr == '0) ? SPR_W'(1) : i_spr;
        n_sum   = r_sum + SW'(SAMPLE_BITS'(i_smp.sample));
        n_count = r_count + 1'b1;
        // count wrapping to zero means 1024 samples
        fire    = (n_count == '0) || (n_count >= target);
        n_total = (n_count == '0) ? N_W'(1 << SPR_W) : N_W'(n_count);
    end

    assign o_push      = take && fire;
    assign o_push_data = {n_sum, n_total};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (take) begin
            if (fire) begin
                r_sum   <= '0;
                r_count <= '0;
            end else begin
                r_sum   <= n_sum;
                r_count <= n_count;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cbc_queue.sv =====
// Small FIFO of finished (sum, count) words between the accumulator and the back end.
// Depends on cbc_pkg for the default depth.
`default_nettype none

module cbc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = cbc_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_ready,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);
    import cbc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CNTW-1:0]  r_cnt;
    logic             do_push, do_pop;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_ready = (r_cnt != CNTW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= bump(r_wr);
            end
            if (do_pop) begin
                r_rd <= bump(r_rd);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cbc_divider.sv =====
// Restoring divider, one quotient bit per cycle, shared by every division of a reading.
// The caller left-aligns the dividend so that i_bits steps leave the quotient in the low bits.
`default_nettype none

module cbc_divider #(
    parameter int QW = 49,
    parameter int DW = 30,
    localparam int CW = $clog2(QW + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [QW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [CW-1:0] i_bits,
    output logic               o_busy,
    output logic [QW-1:0]      o_quo
);
    import cbc_pkg::*;

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [QW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    always_comb begin
        trial = {r_rem, r_quo[QW-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[QW-2:0], ge};
            r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start && !r_busy) begin
            r_busy <= (i_bits != '0);
            r_cnt  <= i_bits;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cbc_back.sv =====
// Reading sequencer: mean, divider resistance, decade and E24 bands, output register.
// Depends on cbc_pkg, cbc_result_if and cbc_divider.
`default_nettype none

module cbc_back #(
    parameter int SAMPLE_BITS = cbc_pkg::SAMPLE_BITS_DEF,
    localparam int SW = SAMPLE_BITS + 10
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_q_valid,
    input  wire logic [SW+cbc_pkg::N_W-1:0]  i_q_data,
    output logic                             o_q_pop,
    input  wire logic [cbc_pkg::KNOWN_W-1:0] i_known,
    input  wire logic [cbc_pkg::FSC_W-1:0]   i_fsc,
    cbc_result_if.source                     o_res
);
    import cbc_pkg::*;

    localparam int LO_W      = SW / 2;
    localparam int HI_W      = SW - LO_W;
    localparam int PLO_W     = KNOWN_W + LO_W;
    localparam int PHI_W     = KNOWN_W + HI_W;
    localparam int NUM_W     = KNOWN_W + SW;
    localparam int N7_W      = NUM_W + 3;
    localparam int QW        = NUM_W + 7;
    localparam int DW        = DEN_W + 7;
    localparam int CW        = $clog2(QW + 1);
    localparam int CMP_W     = (SW > DEN_W) ? SW : DEN_W;
    localparam int MEAN_BITS = SW + 2;
    localparam int RES_BITS  = NUM_W + 2;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PREP  = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_NUM   = 4'd3;
    localparam logic [3:0] ST_N7    = 4'd4;
    localparam logic [3:0] ST_N105  = 4'd5;
    localparam logic [3:0] ST_WMEAN = 4'd6;
    localparam logic [3:0] ST_RES   = 4'd7;
    localparam logic [3:0] ST_EDIV  = 4'd8;
    localparam logic [3:0] ST_SDIV  = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    logic [3:0]         r_state, n_state;
    logic [SW-1:0]      r_sum;
    logic [N_W-1:0]     r_n;
    logic [DEN_W-1:0]   r_full;
    logic [PLO_W-1:0]   r_plo;
    logic [PHI_W-1:0]   r_phi;
    logic               r_open;
    logic [DEN_W-1:0]   r_den;
    logic [NUM_W-1:0]   r_num;
    logic [N7_W-1:0]    r_n7;
    logic [QW-1:0]      r_n105;
    logic [DW-1:0]      r_den100;
    logic [MEAN_W-1:0]  r_mean;
    logic [RES_W-1:0]   r_res;
    logic [MULT_W-1:0]  r_mult;
    logic [DIGIT_W-1:0] r_d1, r_d2;
    logic               r_out_valid;
    t_result            r_out;

    logic               div_start, div_busy;
    logic [QW-1:0]      div_num, div_quo;
    logic [DW-1:0]      div_den;
    logic [CW-1:0]      div_bits;
    logic [MEAN_BITS-1:0] mean_num;
    logic [RES_BITS-1:0]  res_num;
    logic [MULT_W-1:0]  e_mult;
    logic [SNUM_W-1:0]  e_clamped;
    logic [E24_IDX_W-1:0] snap_idx;
    logic               out_free;

    cbc_divider #(
        .QW (QW),
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_bits  (div_bits),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    always_comb begin
        mean_num = MEAN_BITS'({r_sum, 1'b0}) + MEAN_BITS'(r_n);
        res_num  = RES_BITS'({r_num, 1'b0}) + RES_BITS'(r_den);

        if (div_quo >= QW'(DEC_TH_4)) begin
            e_mult = MULT_4;
        end else if (div_quo >= QW'(DEC_TH_3)) begin
            e_mult = MULT_3;
        end else if (div_quo >= QW'(DEC_TH_2)) begin
            e_mult = MULT_2;
        end else if (div_quo >= QW'(DEC_TH_1)) begin
            e_mult = MULT_1;
        end else begin
            e_mult = MULT_0;
        end
        e_clamped = (div_quo > QW'(E_CLAMP)) ? SNUM_W'(E_CLAMP) : div_quo[SNUM_W-1:0];
        snap_idx  = snap_index(div_quo[6:0]);
        out_free  = !r_out_valid || o_res.ready;
    end

    always_comb begin
        n_state   = r_state;
        o_q_pop   = 1'b0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        div_bits  = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                div_start = 1'b1;
                div_num   = QW'(mean_num) << (QW - MEAN_BITS);
                div_den   = DW'({r_n, 1'b0});
                div_bits  = CW'(MEAN_BITS);
                n_state   = ST_MUL;
            end
            ST_MUL:  n_state = ST_NUM;
            ST_NUM:  n_state = ST_N7;
            ST_N7:   n_state = ST_N105;
            ST_N105: n_state = ST_WMEAN;
            ST_WMEAN: begin
                if (!div_busy) begin
                    if (r_open) begin
                        n_state = ST_DONE;
                    end else begin
                        div_start = 1'b1;
                        div_num   = QW'(res_num) << (QW - RES_BITS);
                        div_den   = DW'({r_den, 1'b0});
                        div_bits  = CW'(RES_BITS);
                        n_state   = ST_RES;
                    end
                end
            end
            ST_RES: begin
                if (!div_busy) begin
                    div_start = 1'b1;
                    div_num   = r_n105;
                    div_den   = r_den100;
                    div_bits  = CW'(QW);
                    n_state   = ST_EDIV;
                end
            end
            ST_EDIV: begin
                if (!div_busy) begin
                    div_start = 1'b1;
                    div_num   = QW'(e_clamped) << (QW - SNUM_W);
                    div_den   = DW'(decade_scale(e_mult));
                    div_bits  = CW'(SNUM_W);
                    n_state   = ST_SDIV;
                end
            end
            ST_SDIV: begin
                if (!div_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    r_sum <= i_q_data[SW+N_W-1:N_W];
                    r_n   <= i_q_data[N_W-1:0];
                end
            end
            ST_PREP: begin
                r_full <= DEN_W'(i_fsc) * DEN_W'(r_n);
                r_plo  <= PLO_W'(i_known) * PLO_W'(r_sum[LO_W-1:0]);
            end
            ST_MUL: begin
                r_phi  <= PHI_W'(i_known) * PHI_W'(r_sum[SW-1:LO_W]);
                r_open <= (CMP_W'(r_full) <= CMP_W'(r_sum));
                r_den  <= DEN_W'(CMP_W'(r_full) - CMP_W'(r_sum));
            end
            ST_NUM: begin
                r_num    <= NUM_W'(r_plo) + (NUM_W'(r_phi) << LO_W);
                // x100 = x64 + x32 + x4
                r_den100 <= (DW'(r_den) << 6) + (DW'(r_den) << 5) + (DW'(r_den) << 2);
            end
            ST_N7: begin
                r_n7 <= (N7_W'(r_num) << 3) - N7_W'(r_num);
            end
            ST_N105: begin
                r_n105 <= (QW'(r_n7) << 4) - QW'(r_n7);
            end
            ST_WMEAN: begin
                if (!div_busy) begin
                    r_mean <= (div_quo > QW'(MEAN_MAX)) ? MEAN_MAX : div_quo[MEAN_W-1:0];
                    if (r_open) begin
                        r_res  <= '1;
                        r_mult <= MULT_0;
                        r_d1   <= '0;
                        r_d2   <= '0;
                    end
                end
            end
            ST_RES: begin
                if (!div_busy) begin
                    r_res <= (div_quo > QW'({RES_W{1'b1}})) ? '1 : div_quo[RES_W-1:0];
                end
            end
            ST_EDIV: begin
                if (!div_busy) begin
                    r_mult <= e_mult;
                end
            end
            ST_SDIV: begin
                if (!div_busy) begin
                    r_d1 <= E24_TENS[snap_idx];
                    r_d2 <= E24_UNITS[snap_idx];
                end
            end
            default: ;
        endcase
    end

    // output register: the next reading is worked on while this one waits
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out.mean_code       <= r_mean;
            r_out.resistance_ohms <= r_res;
            r_out.open_circuit    <= r_open;
            r_out.first_digit     <= r_d1;
            r_out.second_digit    <= r_d2;
            r_out.multiplier      <= r_mult;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

`default_nettype wire
